// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an active-low reset that disables it
`define HHD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define HHD_ASSERT(label, prop, msg) \
    `HHD_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/hhd_pkg.sv =====
// shared types and constants of the heading hold drive controller
`default_nettype none

package hhd_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_FORWARD   = 3'd1,
        OP_BACK      = 3'd2,
        OP_LEFT      = 3'd3,
        OP_RIGHT     = 3'd4,
        OP_STOP      = 3'd5,
        OP_RESET_HDG = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        MODE_STOP   = 3'd0,
        MODE_FWD    = 3'd1,
        MODE_BACK   = 3'd2,
        MODE_LEFT   = 3'd3,
        MODE_RIGHT  = 3'd4,
        MODE_SETTLE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        CFG_TRIM_STEP       = 3'd0,
        CFG_HEADING_TOL     = 3'd1,
        CFG_TURN_DUTY       = 3'd2,
        CFG_MIN_DUTY        = 3'd3,
        CFG_MAX_DUTY        = 3'd4,
        CFG_SETTLE_NEEDED   = 3'd5,
        CFG_SETTLE_LIMIT    = 3'd6,
        CFG_WRONG_WAY_LIMIT = 3'd7
    } t_cfg_idx;

    // line order: left fwd, left back, right fwd, right back
    localparam logic [3:0] LINES_OFF        = 4'h0;
    localparam logic [3:0] LINES_FWD        = 4'hA;
    localparam logic [3:0] LINES_BACK       = 4'h5;
    localparam logic [3:0] LINES_TURN_L     = 4'h2;
    localparam logic [3:0] LINES_TURN_L_REV = 4'h1;
    localparam logic [3:0] LINES_TURN_R     = 4'h8;
    localparam logic [3:0] LINES_TURN_R_REV = 4'h4;
    localparam logic [3:0] LINES_PIVOT_L    = 4'h6;
    localparam logic [3:0] LINES_PIVOT_R    = 4'h9;

    localparam logic [13:0] DIST_RESET   = 14'h3FFF;
    localparam logic [7:0]  RUN_L_RESET  = 8'd215;
    localparam logic [7:0]  RUN_R_RESET  = 8'd130;

    typedef struct packed {
        logic [7:0] trim_step;
        logic [7:0] heading_tol;
        logic [7:0] turn_duty;
        logic [7:0] min_duty;
        logic [7:0] max_duty;
        logic [3:0] settle_needed;
        logic [6:0] settle_limit;
        logic [2:0] wrong_way_limit;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] lines;
        logic [7:0] duty_l;
        logic [7:0] duty_r;
        logic       pulse;
    } t_result;

endpackage

`default_nettype wire

// ===== design/heading_hold_drive_controller.sv =====
// top level of the heading hold drive controller
// usage:
//   input channel: i_in_valid with i_operation, i_heading_sample and
//   i_turn_degrees; the block holds o_in_stall high when it cannot take a beat
//   output channel: o_out_valid with the drive mode, four motor lines, two
//   duties and the pivot pulse flag; the receiver holds i_out_stall to wait
//   every input beat gives exactly one output beat, in order
//   an accepted beat waits in the input register; state update and result
//   capture then share the same edge, which writes the output register; that
//   edge is held off while the receiver stalls a pending result
//   throughput is one beat per cycle while the receiver does not stall
//   a stalled result keeps its value and the input register still takes one
//   more beat, after which o_in_stall rises
//   configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
//   at the clock edge; write only while no beat is in flight
//   reset (i_rst_n low, synchronous) empties both registers, loads default
//   configuration and returns the controller to stop with lines off
`default_nettype none

module heading_hold_drive_controller
    import hhd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_operation,
    input  wire logic [8:0] i_heading_sample,
    input  wire logic [7:0] i_turn_degrees,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_drive_mode,
    output logic            o_left_forward,
    output logic            o_left_backward,
    output logic            o_right_forward,
    output logic            o_right_backward,
    output logic [7:0]      o_left_duty,
    output logic [7:0]      o_right_duty,
    output logic            o_pivot_pulse
);

    t_cfg       cfg;
    t_result    res;
    logic       advance;
    logic       in_take;

    logic       r_in_valid;
    logic [2:0] r_op;
    logic [8:0] r_heading;
    logic [7:0] r_degrees;
    logic       r_out_valid;
    t_result    r_res;

    hhd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hhd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_step    (advance),
        .i_op      (r_op),
        .i_heading (r_heading),
        .i_degrees (r_degrees),
        .o_res     (res)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op      <= i_operation;
            r_heading <= i_heading_sample;
            r_degrees <= i_turn_degrees;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive_mode     = r_res.mode;
    assign o_left_forward   = r_res.lines[3];
    assign o_left_backward  = r_res.lines[2];
    assign o_right_forward  = r_res.lines[1];
    assign o_right_backward = r_res.lines[0];
    assign o_left_duty      = r_res.duty_l;
    assign o_right_duty     = r_res.duty_r;
    assign o_pivot_pulse    = r_res.pulse;

endmodule

`default_nettype wire

// ===== design/hhd_cfg_regs.sv =====
// configuration register file
`default_nettype none

module hhd_cfg_regs
    import hhd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trim_step       <= 8'd2;
            r_cfg.heading_tol     <= 8'd1;
            r_cfg.turn_duty       <= 8'd120;
            r_cfg.min_duty        <= 8'd90;
            r_cfg.max_duty        <= 8'd255;
            r_cfg.settle_needed   <= 4'd10;
            r_cfg.settle_limit    <= 7'd100;
            r_cfg.wrong_way_limit <= 3'd5;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TRIM_STEP:       r_cfg.trim_step       <= i_cfg_data;
                CFG_HEADING_TOL:     r_cfg.heading_tol     <= i_cfg_data;
                CFG_TURN_DUTY:       r_cfg.turn_duty       <= i_cfg_data;
                CFG_MIN_DUTY:        r_cfg.min_duty        <= i_cfg_data;
                CFG_MAX_DUTY:        r_cfg.max_duty        <= i_cfg_data;
                CFG_SETTLE_NEEDED:   r_cfg.settle_needed   <= i_cfg_data[3:0];
                CFG_SETTLE_LIMIT:    r_cfg.settle_limit    <= i_cfg_data[6:0];
                CFG_WRONG_WAY_LIMIT: r_cfg.wrong_way_limit <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/hhd_core.sv =====
// controller state and per-beat next-state logic
`default_nettype none

module hhd_core
    import hhd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_step,
    input  wire logic [2:0] i_op,
    input  wire logic [8:0] i_heading,
    input  wire logic [7:0] i_degrees,
    output t_result         o_res
);

    t_mode              r_mode,     n_mode;
    logic signed [8:0]  r_target,   n_target;
    logic [13:0]        r_prev,     n_prev;
    logic               r_rev,      n_rev;
    logic [2:0]         r_wcount,   n_wcount;
    logic [3:0]         r_settled,  n_settled;
    logic [6:0]         r_sticks,   n_sticks;
    logic [7:0]         r_run_l,    n_run_l;
    logic [7:0]         r_run_r,    n_run_r;
    logic [3:0]         r_lines,    n_lines;
    logic [7:0]         r_cmp_l,    n_cmp_l;
    logic [7:0]         r_cmp_r,    n_cmp_r;

    logic signed [8:0]  hdg_raw;
    logic signed [8:0]  cur;
    logic signed [9:0]  diff;
    logic [9:0]         absd;
    logic [7:0]         hdg_err;
    logic               short_left;
    logic signed [10:0] cur_w;
    logic signed [10:0] tgt_hi;
    logic signed [10:0] tgt_lo;
    logic [7:0]         l_plus, l_minus, r_plus, r_minus;
    logic signed [9:0]  turn_sum;
    logic signed [9:0]  turn_tgt;
    logic [3:0]         wnext;
    logic [7:0]         tnext;
    logic               pulse;
    logic [3:0]         pulse_lines;

    function automatic logic [7:0] clamp_duty(input logic signed [9:0] v,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
        logic [7:0] res;
        if (v < $signed({2'b00, lo})) begin
            res = lo;
        end else if (v > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // sample clamp, heading geometry, trimmed duties and turn target
    always_comb begin
        hdg_raw = $signed(i_heading);
        if (hdg_raw > 9'sd180) begin
            cur = 9'sd180;
        end else if (hdg_raw < -9'sd180) begin
            cur = -9'sd180;
        end else begin
            cur = hdg_raw;
        end
        diff = {cur[8], cur} - {r_target[8], r_target};
        absd = diff[9] ? 10'(-diff) : 10'(diff);
        hdg_err = (absd > 10'd180) ? 8'(10'd360 - absd) : absd[7:0];
        short_left = diff[9] ? (diff > -10'sd180) : (diff >= 10'sd180);
        cur_w  = 11'(cur);
        tgt_hi = 11'(r_target) + $signed({3'b000, i_cfg.heading_tol});
        tgt_lo = 11'(r_target) - $signed({3'b000, i_cfg.heading_tol});
        l_plus  = clamp_duty($signed({2'b00, r_cmp_l}) + $signed({2'b00, i_cfg.trim_step}),
                             i_cfg.min_duty, i_cfg.max_duty);
        l_minus = clamp_duty($signed({2'b00, r_cmp_l}) - $signed({2'b00, i_cfg.trim_step}),
                             i_cfg.min_duty, i_cfg.max_duty);
        r_plus  = clamp_duty($signed({2'b00, r_cmp_r}) + $signed({2'b00, i_cfg.trim_step}),
                             i_cfg.min_duty, i_cfg.max_duty);
        r_minus = clamp_duty($signed({2'b00, r_cmp_r}) - $signed({2'b00, i_cfg.trim_step}),
                             i_cfg.min_duty, i_cfg.max_duty);
        if (t_op'(i_op) == OP_LEFT) begin
            turn_sum = 10'(cur) + $signed({2'b00, i_degrees});
            turn_tgt = (turn_sum > 10'sd180) ? turn_sum - 10'sd360 : turn_sum;
        end else begin
            turn_sum = 10'(cur) - $signed({2'b00, i_degrees});
            turn_tgt = (turn_sum < -10'sd180) ? turn_sum + 10'sd360 : turn_sum;
        end
        wnext = {1'b0, r_wcount} + 4'd1;
        tnext = {1'b0, r_sticks} + 8'd1;
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_target  = r_target;
        n_prev    = r_prev;
        n_rev     = r_rev;
        n_wcount  = r_wcount;
        n_settled = r_settled;
        n_sticks  = r_sticks;
        n_run_l   = r_run_l;
        n_run_r   = r_run_r;
        n_lines   = r_lines;
        n_cmp_l   = r_cmp_l;
        n_cmp_r   = r_cmp_r;
        pulse       = 1'b0;
        pulse_lines = LINES_OFF;

        case (t_op'(i_op))
            OP_TICK: begin
                case (r_mode)
                    MODE_FWD: begin
                        if (hdg_err >= i_cfg.heading_tol) begin
                            if (short_left) begin
                                n_run_l = l_minus;
                                n_run_r = r_plus;
                            end else begin
                                n_run_l = l_plus;
                                n_run_r = r_minus;
                            end
                            n_cmp_l = n_run_l;
                            n_cmp_r = n_run_r;
                        end
                    end
                    MODE_BACK: begin
                        if (cur_w > tgt_hi) begin
                            n_run_l = l_minus;
                            n_run_r = r_plus;
                            n_cmp_l = l_minus;
                            n_cmp_r = r_plus;
                        end else if (cur_w < tgt_lo) begin
                            n_run_l = l_plus;
                            n_run_r = r_minus;
                            n_cmp_l = l_plus;
                            n_cmp_r = r_minus;
                        end
                    end
                    MODE_LEFT, MODE_RIGHT: begin
                        if (hdg_err <= i_cfg.heading_tol) begin
                            n_mode    = MODE_SETTLE;
                            n_settled = 4'd0;
                            n_sticks  = 7'd0;
                        end else begin
                            if (r_mode == MODE_LEFT) begin
                                n_lines = r_rev ? LINES_TURN_L_REV : LINES_TURN_L;
                            end else begin
                                n_lines = r_rev ? LINES_TURN_R_REV : LINES_TURN_R;
                            end
                            n_cmp_l = i_cfg.turn_duty;
                            n_cmp_r = i_cfg.turn_duty;
                        end
                        if ({6'd0, hdg_err} > r_prev) begin
                            if (wnext > {1'b0, i_cfg.wrong_way_limit}) begin
                                n_rev    = ~r_rev;
                                n_wcount = 3'd0;
                            end else begin
                                n_wcount = wnext[2:0];
                            end
                        end else begin
                            n_wcount = 3'd0;
                        end
                        n_prev = {6'd0, hdg_err};
                    end
                    MODE_SETTLE: begin
                        n_sticks = tnext[7] ? 7'd127 : tnext[6:0];
                        if (r_settled > i_cfg.settle_needed ||
                            tnext > {1'b0, i_cfg.settle_limit}) begin
                            n_mode  = MODE_STOP;
                            n_lines = LINES_OFF;
                            n_cmp_l = 8'd0;
                            n_cmp_r = 8'd0;
                        end else if (hdg_err <= i_cfg.heading_tol) begin
                            if (r_settled != 4'd15) begin
                                n_settled = r_settled + 4'd1;
                            end
                            n_lines = LINES_OFF;
                        end else begin
                            n_settled   = 4'd0;
                            pulse       = 1'b1;
                            pulse_lines = short_left ? LINES_PIVOT_L : LINES_PIVOT_R;
                            n_cmp_l     = i_cfg.turn_duty;
                            n_cmp_r     = i_cfg.turn_duty;
                            n_lines     = LINES_OFF;
                        end
                    end
                    default: ;
                endcase
            end
            OP_FORWARD, OP_BACK: begin
                n_mode  = (t_op'(i_op) == OP_FORWARD) ? MODE_FWD : MODE_BACK;
                n_lines = (t_op'(i_op) == OP_FORWARD) ? LINES_FWD : LINES_BACK;
                n_cmp_l = r_run_l;
                n_cmp_r = r_run_r;
            end
            OP_LEFT, OP_RIGHT: begin
                if (i_degrees <= 8'd180) begin
                    n_mode   = (t_op'(i_op) == OP_LEFT) ? MODE_LEFT : MODE_RIGHT;
                    n_target = turn_tgt[8:0];
                    n_prev   = DIST_RESET;
                    n_rev    = 1'b0;
                    n_wcount = 3'd0;
                end
            end
            OP_STOP: begin
                n_mode  = MODE_STOP;
                n_lines = LINES_OFF;
                n_cmp_l = 8'd0;
                n_cmp_r = 8'd0;
            end
            OP_RESET_HDG: begin
                n_target = cur;
            end
            default: ;
        endcase

        o_res.mode   = n_mode;
        o_res.lines  = pulse ? pulse_lines : n_lines;
        o_res.duty_l = n_cmp_l;
        o_res.duty_r = n_cmp_r;
        o_res.pulse  = pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STOP;
            r_target  <= 9'sd0;
            r_prev    <= DIST_RESET;
            r_rev     <= 1'b0;
            r_wcount  <= 3'd0;
            r_settled <= 4'd0;
            r_sticks  <= 7'd0;
            r_run_l   <= RUN_L_RESET;
            r_run_r   <= RUN_R_RESET;
            r_lines   <= LINES_OFF;
            r_cmp_l   <= 8'd0;
            r_cmp_r   <= 8'd0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_target  <= n_target;
            r_prev    <= n_prev;
            r_rev     <= n_rev;
            r_wcount  <= n_wcount;
            r_settled <= n_settled;
            r_sticks  <= n_sticks;
            r_run_l   <= n_run_l;
            r_run_r   <= n_run_r;
            r_lines   <= n_lines;
            r_cmp_l   <= n_cmp_l;
            r_cmp_r   <= n_cmp_r;
        end
    end

endmodule

`default_nettype wire

// ===== design/hhd_checker.sv =====
// port-level assertions for the heading hold drive controller, with bind
`default_nettype none

`include "assert_macros.svh"

module hhd_checker
    import hhd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_drive_mode,
    input wire logic       o_left_forward,
    input wire logic       o_left_backward,
    input wire logic       o_right_forward,
    input wire logic       o_right_backward,
    input wire logic [7:0] o_left_duty,
    input wire logic [7:0] o_right_duty,
    input wire logic       o_pivot_pulse
);

    `HHD_ASSERT(a_pulse_only_settling,
        o_out_valid && o_pivot_pulse |-> o_drive_mode == MODE_SETTLE,
        "pivot pulse outside settling")

    `HHD_ASSERT(a_stop_is_quiet,
        o_out_valid && o_drive_mode == MODE_STOP |->
            !o_left_forward && !o_left_backward && !o_right_forward &&
            !o_right_backward && o_left_duty == 8'd0 && o_right_duty == 8'd0,
        "stop mode with lines or duty active")

    `HHD_ASSERT(a_pivot_pattern,
        o_out_valid && o_pivot_pulse |->
            (!o_left_forward && o_left_backward && o_right_forward && !o_right_backward) ||
            (o_left_forward && !o_left_backward && !o_right_forward && o_right_backward),
        "pivot pulse with a bad line pattern")

    `HHD_ASSERT(a_forward_lines,
        o_out_valid && o_drive_mode == MODE_FWD |->
            o_left_forward && !o_left_backward && o_right_forward && !o_right_backward,
        "forward mode with wrong lines")

    `HHD_ASSERT(a_stall_holds,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_mode) &&
            $stable(o_left_duty) && $stable(o_right_duty) && $stable(o_pivot_pulse),
        "stalled output beat changed")

endmodule

bind heading_hold_drive_controller hhd_checker u_hhd_checker (.*);

`default_nettype wire
